// ----- rtl/srl_pkg.sv -----
package srl_pkg;

  // Default number of records held by the list.
  localparam int unsigned CapacityDefault = 16;

  // Field widths of the words on both channels.
  localparam int unsigned KindW    = 3;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned CountW   = 5;

  // Command codes; the two codes left over are ignored commands.
  typedef enum logic [KindW-1:0] {
    KindAppend      = 3'd0,
    KindPrepend     = 3'd1,
    KindOrdered     = 3'd2,
    KindRemoveLast  = 3'd3,
    KindRemoveFirst = 3'd4,
    KindRemoveKey   = 3'd5
  } kind_e;

  // One stored record.
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PayloadW-1:0]    payload;
  } srl_rec_t;

  // Input word.
  typedef struct packed {
    logic [KindW-1:0]       kind;
    logic signed [KeyW-1:0] key;
    logic [PayloadW-1:0]    payload;
  } srl_item_t;

  // Result word.
  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] count;
    logic              full_res;
    logic              empty_res;
  } srl_res_t;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic             go;
    logic [KindW-1:0] kind;
    srl_rec_t         rec;
  } srl_cmd_t;

endpackage

// ----- rtl/sorted_record_list_top.sv -----
// Fixed-capacity list of records (signed key plus payload) held in a row of
// Capacity cells, one record per cell. Each input word carries one command:
// append, prepend, insert in key order ahead of the first record whose key is
// not smaller, remove last, remove first, or remove the first record with a
// matching key. Every command is carried out as it is accepted and its result word is
// registered, so a new command is accepted in every cycle while the output is
// not stalled; the result word follows in the cycle after acceptance. The clock period
// is set by the mark chain, which ripples through all Capacity cells to find
// the insertion or removal point before the cells shift in the same edge.
// Records hold no reset value; only the entry count and the output valid flag are cleared by reset.
module sorted_record_list_top #(
  parameter int unsigned Capacity = srl_pkg::CapacityDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  srl_pkg::srl_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output srl_pkg::srl_res_t  out_data_o
);
  import srl_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic [CntW-1:0] count_next;
  logic            out_valid_q;
  logic            out_valid_d;
  srl_res_t        out_q;
  srl_res_t        out_d;

  logic            accept;
  logic            full;
  logic            empty;
  logic            go;
  logic            ok;
  logic            found;
  srl_cmd_t        cmd;

  logic [Capacity-1:0] occupied;
  logic [Capacity:0]   mark_chain;
  srl_rec_t            rec_w [Capacity];

  // The output register is the only buffer; it frees up when its word is taken.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(Capacity));
  assign empty = (count_q == '0);

  // Decide whether the command succeeds and what the count becomes.
  always_comb begin
    go         = 1'b0;
    ok         = 1'b0;
    count_next = count_q;
    case (in_data_i.kind)
      KindAppend, KindPrepend, KindOrdered: begin
        if (!full) begin
          go         = 1'b1;
          ok         = 1'b1;
          count_next = count_q + CntW'(1);
        end
      end
      KindRemoveLast: begin
        if (!empty) begin
          ok         = 1'b1;
          count_next = count_q - CntW'(1);
        end
      end
      KindRemoveFirst: begin
        if (!empty) begin
          go         = 1'b1;
          ok         = 1'b1;
          count_next = count_q - CntW'(1);
        end
      end
      KindRemoveKey: begin
        if (!empty) begin
          go = 1'b1;
          if (found) begin
            ok         = 1'b1;
            count_next = count_q - CntW'(1);
          end
        end
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // Command broadcast to the cells.
  assign cmd.go          = accept && go;
  assign cmd.kind        = in_data_i.kind;
  assign cmd.rec.key     = in_data_i.key;
  assign cmd.rec.payload = in_data_i.payload;

  assign mark_chain[0] = 1'b0;
  assign found         = mark_chain[Capacity];

  // The row of cells; each sees its neighbours' records.
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    srl_rec_t left_w;
    srl_rec_t right_w;

    assign occupied[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_first
      assign left_w = cmd.rec;
    end else begin : g_inner_left
      assign left_w = rec_w[g-1];
    end

    if (g == Capacity - 1) begin : g_last
      assign right_w = rec_w[g];
    end else begin : g_inner_right
      assign right_w = rec_w[g+1];
    end

    srl_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (occupied[g]),
      .mark_before_i (mark_chain[g]),
      .left_i        (left_w),
      .right_i       (right_w),
      .mark_o        (mark_chain[g+1]),
      .rec_o         (rec_w[g])
    );
  end

  // Result word and next control state.
  always_comb begin
    count_d         = accept ? count_next : count_q;
    out_d.ok        = ok;
    out_d.count     = CountW'(count_next);
    out_d.full_res  = (count_next == CntW'(Capacity));
    out_d.empty_res = (count_next == '0);
    out_valid_d     = accept ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register; loads only with a newly accepted word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  // The count only moves when a word is accepted.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> count_q == $past(count_q))
    else $error("entry count changed without a command");

  // An insert into a full list leaves the count alone and reports failure.
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (in_data_i.kind == KindAppend ||
      in_data_i.kind == KindPrepend || in_data_i.kind == KindOrdered))
    |=> (count_q == $past(count_q)) && !out_q.ok)
    else $error("insert into full list was not refused");

endmodule

// ----- rtl/srl_cell.sv -----
module srl_cell (
  input  logic             clk_i,
  input  srl_pkg::srl_cmd_t cmd_i,
  input  logic             occupied_i,
  input  logic             mark_before_i,
  input  srl_pkg::srl_rec_t left_i,
  input  srl_pkg::srl_rec_t right_i,
  output logic             mark_o,
  output srl_pkg::srl_rec_t rec_o
);
  import srl_pkg::*;

  srl_rec_t rec_q;
  srl_rec_t rec_d;
  logic     mark_self;

  // This cell is the insertion point or the entry to be removed when it is the
  // first cell in the row to raise its mark.
  always_comb begin
    case (cmd_i.kind)
      KindAppend:      mark_self = !occupied_i;
      KindPrepend:     mark_self = 1'b1;
      KindOrdered:     mark_self = !(occupied_i &&
                                     ($signed(rec_q.key) < $signed(cmd_i.rec.key)));
      KindRemoveFirst: mark_self = occupied_i;
      KindRemoveKey:   mark_self = occupied_i && (rec_q.key == cmd_i.rec.key);
      default:         mark_self = 1'b0;
    endcase
  end

  assign mark_o = mark_before_i | mark_self;

  // Inserts shift the tail one place up; removals of the first record or of a key pull it one place down.
  always_comb begin
    rec_d = rec_q;
    if (cmd_i.go) begin
      case (cmd_i.kind)
        KindAppend, KindPrepend, KindOrdered: begin
          if (mark_before_i) begin
            rec_d = left_i;
          end else if (mark_self) begin
            rec_d = cmd_i.rec;
          end
        end
        KindRemoveFirst, KindRemoveKey: begin
          if (mark_o) begin
            rec_d = right_i;
          end
        end
        default: rec_d = rec_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ----- tb/tb_sorted_record_list_top.sv -----
module tb_sorted_record_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srl_pkg::*;

  localparam int unsigned Cap = CapacityDefault;

  // The two command codes that the block ignores.
  localparam logic [KindW-1:0] KindSpareLo = 3'd6;
  localparam logic [KindW-1:0] KindSpareHi = 3'd7;

  localparam logic signed [KeyW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KeyMax = 32'sh7fff_ffff;

  localparam int unsigned RandomItems = 1500;
  localparam int unsigned HoldCycles  = 60;

  // One row of the directed table: a command word and, where it is obvious,
  // the result word typed in by hand.
  typedef struct {
    srl_item_t word;
    bit        typed;
    srl_res_t  res;
  } step_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  srl_item_t in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  srl_res_t  out_data_o;

  // Shadow copy of the list, advanced once per accepted command word.
  srl_rec_t  shadow_rec [Cap];
  int        shadow_count = 0;

  step_row_t offered_rows [$];
  srl_res_t  pending_results [$];

  int errors        = 0;
  int commands_in   = 0;
  int results_seen  = 0;
  int refused_seen  = 0;
  int full_seen     = 0;
  int empty_seen    = 0;

  // Shared between the two sides: calm turns all idling off, and the hold
  // request asks the receiver for one long hold-off.
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  sorted_record_list_top #(
    .Capacity (Cap)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one command to the shadow list and returns the result it gives.
  function automatic srl_res_t list_step(srl_item_t w);
    srl_res_t r;
    int       pos;
    r   = '0;
    pos = 0;
    case (w.kind)
      KindAppend, KindPrepend, KindOrdered: begin
        if (shadow_count < Cap) begin
          if (w.kind == KindAppend) begin
            pos = shadow_count;
          end else if (w.kind == KindOrdered) begin
            while (pos < shadow_count && shadow_rec[pos].key < w.key) pos++;
          end
          for (int k = shadow_count; k > pos; k--) shadow_rec[k] = shadow_rec[k-1];
          shadow_rec[pos].key     = w.key;
          shadow_rec[pos].payload = w.payload;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      KindRemoveLast: begin
        if (shadow_count > 0) begin
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      KindRemoveFirst, KindRemoveKey: begin
        if (shadow_count > 0) begin
          if (w.kind == KindRemoveKey) begin
            while (pos < shadow_count && shadow_rec[pos].key != w.key) pos++;
          end
          if (pos < shadow_count) begin
            for (int k = pos; k + 1 < shadow_count; k++) shadow_rec[k] = shadow_rec[k+1];
            shadow_count--;
            r.ok = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.count     = shadow_count[CountW-1:0];
    r.full_res  = (shadow_count == Cap);
    r.empty_res = (shadow_count == 0);
    return r;
  endfunction

  // Builds a table row; the fill flags of a typed result follow from its count.
  function automatic step_row_t row(logic [KindW-1:0] kind, logic signed [KeyW-1:0] key,
                                    logic [PayloadW-1:0] payload, bit typed = 1'b0,
                                    bit ok = 1'b0, int count = 0);
    step_row_t s;
    s.word.kind     = kind;
    s.word.key      = key;
    s.word.payload  = payload;
    s.typed         = typed;
    s.res.ok        = ok;
    s.res.count     = count[CountW-1:0];
    s.res.full_res  = (count == Cap);
    s.res.empty_res = (count == 0);
    return s;
  endfunction

  // Keys mostly come from a narrow band so that ordered inserts meet equal
  // keys and key removals hit; the rest are extremes or fully random.
  function automatic logic signed [KeyW-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      6:       return KeyMin;
      7:       return KeyMax;
      8, 9:    return $urandom();
      default: return int'($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  // Draws a random command, leaning towards inserts or removals by phase.
  function automatic srl_item_t draw_word(bit filling);
    srl_item_t w;
    int        roll;
    int        pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 3);
    if (roll < 3) begin
      w.kind = pick[0] ? KindSpareHi : KindSpareLo;
    end else if ((roll < 70) == filling) begin
      case (pick)
        0:       w.kind = KindAppend;
        1:       w.kind = KindPrepend;
        default: w.kind = KindOrdered;
      endcase
    end else begin
      case (pick)
        0:       w.kind = KindRemoveLast;
        1:       w.kind = KindRemoveFirst;
        default: w.kind = KindRemoveKey;
      endcase
    end
    w.key     = pick_key();
    w.payload = $urandom();
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic compare_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Offers one word, idling first at random, and returns once it is taken.
  task automatic send_word(step_row_t s);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    offered_rows.push_back(s);
    in_valid_i <= 1'b1;
    in_data_i  <= s.word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin : drain_side
    int held;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 37);
    end
  end

  // Watches both channels: predicts on every accepted command word and
  // compares every accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : check_side
    step_row_t tag;
    srl_res_t  want;
    srl_res_t  got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tag  = offered_rows.pop_front();
        want = list_step(in_data_i);
        pending_results.push_back(tag.typed ? tag.res : want);
        commands_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word", got, 0);
        end else begin
          want = pending_results.pop_front();
          compare_field("ok", got.ok, want.ok);
          compare_field("count", got.count, want.count);
          compare_field("full_res", got.full_res, want.full_res);
          compare_field("empty_res", got.empty_res, want.empty_res);
        end
        results_seen++;
        if (!got.ok) refused_seen++;
        if (got.full_res) full_seen++;
        if (got.empty_res) empty_seen++;
      end
    end
  end

  // Main sequence: reset, the directed table, then the random stream.
  initial begin : feed_side
    step_row_t directed_rows [$];
    step_row_t s;
    bit        filling;

    // Removals and ignored codes on the empty list.
    directed_rows.push_back(row(KindRemoveLast, 0, 0, 1, 0, 0));
    directed_rows.push_back(row(KindRemoveFirst, 0, 0, 1, 0, 0));
    directed_rows.push_back(row(KindRemoveKey, 0, 0, 1, 0, 0));
    directed_rows.push_back(row(KindSpareLo, KeyMax, 32'hffff_ffff, 1, 0, 0));
    directed_rows.push_back(row(KindSpareHi, KeyMin, 32'h0000_0000, 1, 0, 0));
    // Filling up with extreme keys and payloads.
    directed_rows.push_back(row(KindAppend, KeyMax, 32'hffff_ffff, 1, 1, 1));
    directed_rows.push_back(row(KindAppend, KeyMin, 32'h0000_0000, 1, 1, 2));
    directed_rows.push_back(row(KindPrepend, 0, 32'h5555_5555, 1, 1, 3));
    directed_rows.push_back(row(KindPrepend, -1, 32'haaaa_aaaa, 1, 1, 4));
    directed_rows.push_back(row(KindOrdered, 0, 32'h0000_0001));
    directed_rows.push_back(row(KindOrdered, KeyMin, 32'h8000_0000));
    directed_rows.push_back(row(KindOrdered, KeyMax, 32'h7fff_ffff));
    directed_rows.push_back(row(KindOrdered, 1, 32'h1234_5678));
    directed_rows.push_back(row(KindOrdered, -5, 32'h0f0f_0f0f));
    directed_rows.push_back(row(KindOrdered, 7, 32'hf0f0_f0f0));
    directed_rows.push_back(row(KindOrdered, KeyMin + 1, 32'h0000_ffff));
    directed_rows.push_back(row(KindOrdered, KeyMax - 1, 32'hffff_0000));
    directed_rows.push_back(row(KindAppend, 3, 32'hdead_beef));
    directed_rows.push_back(row(KindPrepend, 9, 32'hcafe_f00d));
    directed_rows.push_back(row(KindOrdered, -1, 32'h0000_0002));
    directed_rows.push_back(row(KindOrdered, 2, 32'h0000_0003));
    // Inserts into the full list, an absent key, then removals.
    directed_rows.push_back(row(KindAppend, 4, 32'h0000_0004, 1, 0, Cap));
    directed_rows.push_back(row(KindOrdered, 4, 32'h0000_0004, 1, 0, Cap));
    directed_rows.push_back(row(KindRemoveKey, 12345, 0, 1, 0, Cap));
    directed_rows.push_back(row(KindRemoveKey, KeyMin, 0));
    directed_rows.push_back(row(KindRemoveFirst, 0, 0));
    directed_rows.push_back(row(KindRemoveLast, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    filling = 1'b1;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) filling = ~filling;
      calm = (n >= 700 && n < 1000);
      if (n == 300) hold_req = 1'b1;
      s.word  = draw_word(filling);
      s.typed = 1'b0;
      s.res   = '0;
      send_word(s);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // Let the checker log the last accepted word before draining.
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d command words and %0d result words, %0d of them refused.",
             commands_in, results_seen, refused_seen);
    $display("The list stood full after %0d commands and empty after %0d.",
             full_seen, empty_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("Timed out with %0d result words outstanding.", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
